/* rtl/fullwidth_to_halfwidth_sjis_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the full-width to half-width converter
// Concurrent checks on the rising clock edge, off while reset is held.
// ----------------------------------------------------------------------------
`ifndef FULLWIDTH_TO_HALFWIDTH_SJIS_CORE_ASSERT_SVH
`define FULLWIDTH_TO_HALFWIDTH_SJIS_CORE_ASSERT_SVH

// same-cycle implication
`define FWHW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fwhw assertion failed: same-cycle check");

// next-cycle implication
`define FWHW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fwhw assertion failed: next-cycle check");

`endif

/* rtl/fwhw_pkg.sv */
// ----------------------------------------------------------------------------
// fwhw_pkg
// Types, constants and byte mapping functions of the Shift-JIS converter.
// ----------------------------------------------------------------------------
package fwhw_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 16;

  localparam logic [CountW-1:0] MaxOutReset = 16'd255;

  localparam logic [ByteW-1:0] LeadAlpha = 8'h82;
  localparam logic [ByteW-1:0] LeadPunct = 8'h81;
  localparam logic [ByteW-1:0] LowerOfs  = 8'h20;
  localparam logic [ByteW-1:0] UpperOfs  = 8'h1f;

  typedef enum logic [1:0] {
    LEAD_NONE  = 2'd0,
    LEAD_82    = 2'd1,
    LEAD_81    = 2'd2,
    LEAD_OTHER = 2'd3
  } lead_e;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             in_last;
  } item_t;

  typedef struct packed {
    logic              out_valid;
    logic [ByteW-1:0]  out_byte;
    logic [CountW-1:0] out_count;
    logic              out_done;
  } result_t;

  typedef struct packed {
    lead_e             lead;
    logic [CountW-1:0] count;
    logic              full;
  } conv_state_t;

  function automatic logic is_lead(input logic [ByteW-1:0] b);
    return ((b >= 8'h81) && (b <= 8'h9f)) || ((b >= 8'he0) && (b <= 8'hfc));
  endfunction

  function automatic logic [ByteW-1:0] map_82(input logic [ByteW-1:0] t);
    logic [ByteW-1:0] m;
    m = '0;
    if ((t >= 8'h81) && (t <= 8'h9a)) begin
      m = t - LowerOfs;
    end else if ((t >= 8'h60) && (t <= 8'h79)) begin
      m = t - UpperOfs;
    end else if ((t >= 8'h4f) && (t <= 8'h58)) begin
      m = t - UpperOfs;
    end
    return m;
  endfunction

  function automatic logic [ByteW-1:0] map_81(input logic [ByteW-1:0] t);
    logic [ByteW-1:0] m;
    case (t)
      8'h69, 8'h6f: m = 8'h28;
      8'h6a, 8'h70: m = 8'h29;
      8'h7e, 8'h96: m = 8'h2a;
      8'h5e, 8'h80: m = 8'h2f;
      8'h7b:        m = 8'h2b;
      8'h7c:        m = 8'h2d;
      8'h81:        m = 8'h3d;
      8'h94:        m = 8'h23;
      8'h41, 8'h43: m = 8'h2c;
      8'h42, 8'h44: m = 8'h2e;
      default:      m = '0;
    endcase
    return m;
  endfunction

endpackage

/* rtl/fwhw_if.sv */
// ----------------------------------------------------------------------------
// fwhw channel interfaces
// Input byte channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface fwhw_in_if
  import fwhw_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface fwhw_out_if
  import fwhw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              out_valid;
  logic [ByteW-1:0]  out_byte;
  logic [CountW-1:0] out_count;
  logic              out_done;

  modport source (output valid, output out_valid, output out_byte, output out_count,
                  output out_done, input ready);
  modport sink   (input valid, input out_valid, input out_byte, input out_count,
                  input out_done, output ready);
endinterface

interface fwhw_cfg_if
  import fwhw_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/fwhw_in_reg.sv */
// ----------------------------------------------------------------------------
// fwhw_in_reg
// Input register: captures one byte item, releases it when the next stage advances.
// ----------------------------------------------------------------------------
module fwhw_in_reg
  import fwhw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  fwhw_in_if.sink     in_i,
  input  logic        advance_i,
  output logic        valid_o,
  output item_t       item_o
);

  logic  valid_q;
  item_t item_q;

  assign in_i.ready = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= '{in_byte: in_i.in_byte, in_last: in_i.in_last};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* rtl/fwhw_decode.sv */
// ----------------------------------------------------------------------------
// fwhw_decode
// Per-byte decode: lead tracking, trail mapping, capacity count and limit.
// ----------------------------------------------------------------------------
module fwhw_decode
  import fwhw_pkg::*;
(
  input  item_t             item_i,
  input  conv_state_t       state_i,
  input  logic [CountW-1:0] max_out_i,
  output result_t           result_o,
  output conv_state_t       state_o
);

  logic              full;
  logic              emit;
  logic [ByteW-1:0]  mapped;
  logic [ByteW-1:0]  ob;
  lead_e             lead_n;
  logic [CountW-1:0] count_n;
  logic              full_n;

  always_comb begin
    full    = state_i.full || (state_i.count >= max_out_i);
    emit    = 1'b0;
    ob      = '0;
    mapped  = '0;
    lead_n  = state_i.lead;
    count_n = state_i.count;
    full_n  = full;

    if (!full) begin
      if (state_i.lead != LEAD_NONE) begin
        case (state_i.lead)
          LEAD_82: mapped = map_82(item_i.in_byte);
          LEAD_81: mapped = map_81(item_i.in_byte);
          default: mapped = '0;
        endcase
        lead_n = LEAD_NONE;
        if (mapped != '0) begin
          emit = 1'b1;
          ob   = mapped;
        end
      end else if (is_lead(item_i.in_byte)) begin
        if (item_i.in_byte == LeadAlpha) begin
          lead_n = LEAD_82;
        end else if (item_i.in_byte == LeadPunct) begin
          lead_n = LEAD_81;
        end else begin
          lead_n = LEAD_OTHER;
        end
      end else begin
        emit = 1'b1;
        ob   = item_i.in_byte;
      end

      if (emit) begin
        count_n = state_i.count + 16'd1;
        if (count_n >= max_out_i) begin
          full_n = 1'b1;
          lead_n = LEAD_NONE;
        end
      end
    end

    result_o = '{out_valid: emit, out_byte: ob, out_count: count_n,
                 out_done: item_i.in_last};

    if (item_i.in_last) begin
      state_o = '{lead: LEAD_NONE, count: '0, full: 1'b0};
    end else begin
      state_o = '{lead: lead_n, count: count_n, full: full_n};
    end
  end

endmodule

/* rtl/fwhw_out_reg.sv */
// ----------------------------------------------------------------------------
// fwhw_out_reg
// Result register: holds one result item until the sink takes it.
// ----------------------------------------------------------------------------
module fwhw_out_reg
  import fwhw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  result_t     result_i,
  output logic        busy_o,
  fwhw_out_if.source  out_o
);

  logic    valid_q;
  result_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign busy_o          = valid_q && !out_o.ready;
  assign out_o.valid     = valid_q;
  assign out_o.out_valid = result_q.out_valid;
  assign out_o.out_byte  = result_q.out_byte;
  assign out_o.out_count = result_q.out_count;
  assign out_o.out_done  = result_q.out_done;

endmodule

/* rtl/fullwidth_to_halfwidth_sjis_core.sv */
// Path: an accepted byte item is held in the input register, then loaded into the result register once that is free.
// Throughput: 1 byte item per cycle while the result sink does not stall; each byte gives exactly one result item.
// The pending-lead, count and full state updates as an item moves to the result register.
// Reset (rst_ni low, asynchronous): state cleared, both stages empty, max_out set to 255.
// ----------------------------------------------------------------------------
// fullwidth_to_halfwidth_sjis_core
// Shift-JIS full-width to half-width ASCII converter, one byte per item.
// ----------------------------------------------------------------------------
`include "fullwidth_to_halfwidth_sjis_core_assert.svh"

module fullwidth_to_halfwidth_sjis_core
  import fwhw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  fwhw_cfg_if.sink    cfg_i,
  fwhw_in_if.sink     in_i,
  fwhw_out_if.source  out_o
);

  logic              in_valid;
  item_t             in_item;
  logic              out_busy;
  logic              advance;
  result_t           result;
  conv_state_t       state_q;
  conv_state_t       state_d;
  logic [CountW-1:0] max_out_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_out_q <= MaxOutReset;
    end else if (cfg_i.valid) begin
      max_out_q <= cfg_i.data;
    end
  end

  assign advance = in_valid && !out_busy;

  fwhw_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (advance),
    .valid_o   (in_valid),
    .item_o    (in_item)
  );

  fwhw_decode u_decode (
    .item_i    (in_item),
    .state_i   (state_q),
    .max_out_i (max_out_q),
    .result_o  (result),
    .state_o   (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{lead: LEAD_NONE, count: '0, full: 1'b0};
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  fwhw_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (result),
    .busy_o   (out_busy),
    .out_o    (out_o)
  );

  `FWHW_ASSERT_NXT(a_last_clears_state, clk_i, rst_ni, advance && in_item.in_last,
                   (state_q.count == '0) && (state_q.lead == LEAD_NONE) && !state_q.full)
  `FWHW_ASSERT_NXT(a_accept_fills_input, clk_i, rst_ni, in_i.valid && in_i.ready, in_valid)
  `FWHW_ASSERT_IMP(a_emit_has_count, clk_i, rst_ni, out_o.valid && out_o.out_valid,
                   out_o.out_count != '0)
  `FWHW_ASSERT_IMP(a_silent_byte_zero, clk_i, rst_ni, advance && !result.out_valid,
                   (result.out_byte == '0) && (result.out_count == state_q.count))

endmodule
